@@ design/square_wave_note_player_assert.svh @@
// assertion macros for the square wave note player
`ifndef SQUARE_WAVE_NOTE_PLAYER_ASSERT_SVH
`define SQUARE_WAVE_NOTE_PLAYER_ASSERT_SVH

`ifndef ASSERT_OFF
// condition must hold at every edge out of reset
`define SWNP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("swnp assertion failed");
// trigger at one edge implies the consequence at the next edge
`define SWNP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("swnp assertion failed");
`else
`define SWNP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SWNP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ design/swnp_pkg.sv @@
// shared types and constants of the square wave note player
package swnp_pkg;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  localparam logic [7:0] REST_CODE          = 8'hFF;
  localparam logic [7:0] WINDOW_TICKS_RESET = 8'd250;

  typedef struct packed {
    logic       kind;
    logic [7:0] half_period;
    logic [7:0] note_length;
    logic [7:0] length_scaler;
    logic       button_pressed;
  } note_item_t;

  typedef struct packed {
    logic buzzer;
    logic lamp;
    logic note_done;
    logic cancelled;
    logic playing;
  } result_t;

  // input register contents handed to the core
  typedef struct packed {
    logic       valid;
    note_item_t item;
  } stage_t;

endpackage

@@ design/swnp_note_if.sv @@
// input channel carrying note starts and timer ticks
interface swnp_note_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] half_period;
  logic [7:0] note_length;
  logic [7:0] length_scaler;
  logic       button_pressed;

  modport source (
    output valid, kind, half_period, note_length, length_scaler, button_pressed,
    input  ready
  );
  modport sink (
    input  valid, kind, half_period, note_length, length_scaler, button_pressed,
    output ready
  );
endinterface

@@ design/swnp_result_if.sv @@
// output channel carrying one result item per input item
interface swnp_result_if;
  logic valid;
  logic ready;
  logic buzzer;
  logic lamp;
  logic note_done;
  logic cancelled;
  logic playing;

  modport source (
    output valid, buzzer, lamp, note_done, cancelled, playing,
    input  ready
  );
  modport sink (
    input  valid, buzzer, lamp, note_done, cancelled, playing,
    output ready
  );
endinterface

@@ design/swnp_in_stage.sv @@
// input register of the note player
module swnp_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  swnp_note_if.sink            note_i,
  input  logic                 advance_i,
  output swnp_pkg::stage_t     stage_o
);

  logic                 valid_q, valid_d;
  swnp_pkg::note_item_t item_q;
  logic                 load;

  // free slot or slot drains this cycle
  assign note_i.ready = !valid_q || advance_i;
  assign load         = note_i.valid && note_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (note_i.ready) begin
      valid_d = note_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.kind           <= note_i.kind;
      item_q.half_period    <= note_i.half_period;
      item_q.note_length    <= note_i.note_length;
      item_q.length_scaler  <= note_i.length_scaler;
      item_q.button_pressed <= note_i.button_pressed;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

@@ design/swnp_core.sv @@
// note state and its next-state logic
module swnp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              step_i,
  input  swnp_pkg::note_item_t item_i,
  output swnp_pkg::result_t result_o
);

  logic [7:0] win_ticks_q, win_ticks_d;
  logic       busy_q, busy_d;
  logic       stop_q, stop_d;
  logic       buzzer_q, buzzer_d;
  logic       lamp_q, lamp_d;
  logic [7:0] period_reload_q, period_reload_d;
  logic [7:0] period_count_q, period_count_d;
  logic [7:0] window_count_q, window_count_d;
  logic [7:0] length_reload_q, length_reload_d;
  logic [7:0] length_count_q, length_count_d;
  logic [7:0] scaler_count_q, scaler_count_d;
  logic       done;
  logic [7:0] period_dec, window_inc, length_dec, scaler_dec;

  assign period_dec = period_count_q - 8'd1;
  assign window_inc = window_count_q + 8'd1;
  assign length_dec = length_count_q - 8'd1;
  assign scaler_dec = scaler_count_q - 8'd1;

  always_comb begin
    win_ticks_d = cfg_we_i ? cfg_wdata_i : win_ticks_q;
  end

  always_comb begin
    busy_d          = busy_q;
    stop_d          = stop_q;
    buzzer_d        = buzzer_q;
    lamp_d          = lamp_q;
    period_reload_d = period_reload_q;
    period_count_d  = period_count_q;
    window_count_d  = window_count_q;
    length_reload_d = length_reload_q;
    length_count_d  = length_count_q;
    scaler_count_d  = scaler_count_q;
    done            = 1'b0;
    if (step_i) begin
      if (item_i.kind == swnp_pkg::KIND_START) begin
        if (!busy_q) begin
          if (stop_q) begin
            // cancelled earlier: finish at once
            busy_d   = 1'b0;
            buzzer_d = 1'b0;
            lamp_d   = 1'b0;
            done     = 1'b1;
          end else begin
            period_reload_d = item_i.half_period;
            period_count_d  = item_i.half_period;
            if (item_i.half_period != swnp_pkg::REST_CODE) begin
              buzzer_d = 1'b1;
              lamp_d   = 1'b1;
            end
            window_count_d  = 8'd0;
            length_reload_d = item_i.note_length;
            length_count_d  = item_i.note_length;
            scaler_count_d  = item_i.length_scaler;
            busy_d          = 1'b1;
          end
        end
      end else if (busy_q) begin
        period_count_d = period_dec;
        if (period_dec == 8'd0) begin
          period_count_d = period_reload_q;
          if (lamp_q) begin
            buzzer_d = !buzzer_q;
          end
        end
        if (item_i.button_pressed) begin
          stop_d   = 1'b1;
          busy_d   = 1'b0;
          buzzer_d = 1'b0;
          lamp_d   = 1'b0;
          done     = 1'b1;
        end else begin
          window_count_d = window_inc;
          if (window_inc >= win_ticks_q) begin
            window_count_d = 8'd0;
            length_count_d = length_dec;
            if (length_dec == 8'd0) begin
              scaler_count_d = scaler_dec;
              if (scaler_dec == 8'd0) begin
                busy_d   = 1'b0;
                buzzer_d = 1'b0;
                lamp_d   = 1'b0;
                done     = 1'b1;
              end else begin
                length_count_d = length_reload_q;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ticks_q     <= swnp_pkg::WINDOW_TICKS_RESET;
      busy_q          <= 1'b0;
      stop_q          <= 1'b0;
      buzzer_q        <= 1'b0;
      lamp_q          <= 1'b0;
      period_reload_q <= 8'd0;
      period_count_q  <= 8'd0;
      window_count_q  <= 8'd0;
      length_reload_q <= 8'd0;
      length_count_q  <= 8'd0;
      scaler_count_q  <= 8'd0;
    end else begin
      win_ticks_q     <= win_ticks_d;
      busy_q          <= busy_d;
      stop_q          <= stop_d;
      buzzer_q        <= buzzer_d;
      lamp_q          <= lamp_d;
      period_reload_q <= period_reload_d;
      period_count_q  <= period_count_d;
      window_count_q  <= window_count_d;
      length_reload_q <= length_reload_d;
      length_count_q  <= length_count_d;
      scaler_count_q  <= scaler_count_d;
    end
  end

  assign result_o.buzzer    = buzzer_d;
  assign result_o.lamp      = lamp_d;
  assign result_o.note_done = done;
  assign result_o.cancelled = stop_d;
  assign result_o.playing   = busy_d;

endmodule

@@ design/swnp_out_stage.sv @@
// result register of the note player
module swnp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  swnp_pkg::result_t result_i,
  output logic              advance_o,
  swnp_result_if.source     result_o
);

  logic              valid_q, valid_d;
  swnp_pkg::result_t result_q;

  // register empty or being taken this cycle
  assign advance_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign result_o.valid     = valid_q;
  assign result_o.buzzer    = result_q.buzzer;
  assign result_o.lamp      = result_q.lamp;
  assign result_o.note_done = result_q.note_done;
  assign result_o.cancelled = result_q.cancelled;
  assign result_o.playing   = result_q.playing;

endmodule

@@ design/square_wave_note_player.sv @@
// path: an accepted item sits in the input register; its result item is computed as it leaves
// and is registered in the result register, from which it can be taken
// throughput: one item per cycle while the output is not stalled; the note state updates in one pass as
// the item leaves the input register, so a start or tick may follow every cycle unless the output stalls
// reset: asynchronous, active low; clears all note state and both registers' valid bits,
// and sets window_ticks back to 250
`include "square_wave_note_player_assert.svh"

// top level of the square wave note player
module square_wave_note_player (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  swnp_note_if.sink      note_i,
  swnp_result_if.source  result_o
);

  // input register contents
  swnp_pkg::stage_t  stage;
  // next result, computed from the registered item and the note state
  swnp_pkg::result_t next_result;
  // result register can take a new item this cycle
  logic              advance;
  // note state moves on exactly when the registered item moves to the result
  logic              step;

  assign step = stage.valid && advance;

  swnp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .note_i    (note_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  // counters for half period, window, length and scaler rounds
  swnp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (stage.item),
    .result_o    (next_result)
  );

  swnp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage.valid),
    .result_i  (next_result),
    .advance_o (advance),
    .result_o  (result_o)
  );

  // a finished note always leaves buzzer and lamp low and the player idle
  `SWNP_ASSERT_ALWAYS(a_done_quiet, clk_i, rst_ni, !(result_o.valid && result_o.note_done) || (!result_o.playing && !result_o.lamp && !result_o.buzzer))
  // lamp only lights while a note is in progress
  `SWNP_ASSERT_ALWAYS(a_lamp_playing, clk_i, rst_ni, !(result_o.valid && result_o.lamp) || result_o.playing)
  // a registered item waiting on a stalled output is not dropped
  `SWNP_ASSERT_NEXT(a_item_kept, clk_i, rst_ni, stage.valid && !advance, stage.valid)

endmodule
